[rtl/core/presence_qualifier_idle_timer_top_defines.svh]
// assertion macros for the presence qualifier block
`ifndef PRESENCE_QUALIFIER_IDLE_TIMER_TOP_DEFINES_SVH
`define PRESENCE_QUALIFIER_IDLE_TIMER_TOP_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PQIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define PQIT_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

[rtl/core/pqit_pkg.sv]
// shared types and constants for the presence qualifier with idle timer
package pqit_pkg;

  localparam int GateW   = 16;
  localparam int HystW   = 10;
  localparam int RunW    = 4;
  localparam int SettleW = 4;
  localparam int IdleW   = 20;
  localparam int CfgW    = 20;
  localparam int IdxW    = 3;

  localparam logic [GateW-1:0]   GateReset   = 16'd500;
  localparam logic [HystW-1:0]   HystReset   = 10'd60;
  localparam logic [RunW-1:0]    RunReset    = 4'd5;
  localparam logic [SettleW-1:0] SettleReset = 4'd5;
  localparam logic [IdleW-1:0]   RestReset   = 20'd60000;

  localparam logic [GateW-1:0] FarReadingMm = 16'hFFFF;
  localparam logic [IdleW-1:0] IdleMax      = 20'hFFFFF;

  localparam logic [IdxW-1:0] RegGate   = 3'd0;
  localparam logic [IdxW-1:0] RegHyst   = 3'd1;
  localparam logic [IdxW-1:0] RegRun    = 3'd2;
  localparam logic [IdxW-1:0] RegSettle = 3'd3;
  localparam logic [IdxW-1:0] RegRest   = 3'd4;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_FAULT  = 2'd1,
    ACT_TOUCH  = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_ON   = 2'd1,
    EDGE_OFF  = 2'd2
  } edge_t;

  typedef struct packed {
    logic            write;
    logic [IdxW-1:0] index;
    logic [CfgW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic  present_now;
    edge_t presence_edge;
    logic  rest_request;
  } result_t;

endpackage

[rtl/core/pqit_core.sv]
// presence qualifier state, configuration registers and per-event update
module pqit_core (
  input  logic                      clk,
  input  logic                      rst,
  input  pqit_pkg::cfg_wr_t         cfg,
  input  logic                      accept,
  input  logic [1:0]                action,
  input  logic [15:0]               range_mm,
  input  logic                      range_status_ok,
  input  logic                      screen_hold,
  output pqit_pkg::result_t         res
);

  logic [pqit_pkg::GateW-1:0]   gate_distance_mm;
  logic [pqit_pkg::HystW-1:0]   hysteresis_mm;
  logic [pqit_pkg::RunW-1:0]    away_run_length;
  logic [pqit_pkg::IdleW-1:0]   rest_after_ms;

  logic [pqit_pkg::SettleW-1:0] settle_left, settle_left_next;
  logic [pqit_pkg::RunW-1:0]    far_run, far_run_next;
  logic                         present_flag, present_flag_next;
  logic [pqit_pkg::IdleW-1:0]   idle_ms, idle_ms_next;

  logic [pqit_pkg::GateW-1:0] reading;
  logic [pqit_pkg::GateW:0]   limit;
  logic                       near;
  logic                       now;
  pqit_pkg::edge_t            edge_code;

  always_comb begin
    reading = range_status_ok ? range_mm : pqit_pkg::FarReadingMm;
    limit = {1'b0, gate_distance_mm};
    if (present_flag) begin
      limit = {1'b0, gate_distance_mm} +
              {{(pqit_pkg::GateW + 1 - pqit_pkg::HystW){1'b0}}, hysteresis_mm};
    end
    near = ({1'b0, reading} <= limit);

    settle_left_next  = settle_left;
    far_run_next      = far_run;
    present_flag_next = present_flag;
    idle_ms_next      = idle_ms;
    edge_code         = pqit_pkg::EDGE_NONE;
    now               = 1'b0;

    case (pqit_pkg::action_t'(action))
      pqit_pkg::ACT_SAMPLE: begin
        if (settle_left != '0) begin
          settle_left_next = settle_left - 1'b1;
        end else begin
          if (near) begin
            far_run_next = '0;
          end else if (far_run < away_run_length) begin
            far_run_next = far_run + 1'b1;
          end
          now = (far_run_next < away_run_length);
          if (now) begin
            idle_ms_next = '0;
          end
          if (now != present_flag) begin
            present_flag_next = now;
            edge_code = now ? pqit_pkg::EDGE_ON : pqit_pkg::EDGE_OFF;
          end
        end
      end
      pqit_pkg::ACT_FAULT, pqit_pkg::ACT_TOUCH: begin
        idle_ms_next = '0;
      end
      pqit_pkg::ACT_TICK: begin
        if (idle_ms != pqit_pkg::IdleMax) begin
          idle_ms_next = idle_ms + 1'b1;
        end
      end
      default: begin
        idle_ms_next = idle_ms;
      end
    endcase

    res.present_now   = present_flag_next;
    res.presence_edge = edge_code;
    res.rest_request  = (idle_ms_next > rest_after_ms) && !screen_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_distance_mm <= pqit_pkg::GateReset;
      hysteresis_mm    <= pqit_pkg::HystReset;
      away_run_length  <= pqit_pkg::RunReset;
      rest_after_ms    <= pqit_pkg::RestReset;
      settle_left      <= pqit_pkg::SettleReset;
      far_run          <= pqit_pkg::RunReset;
      present_flag     <= 1'b0;
      idle_ms          <= '0;
    end else if (cfg.write) begin
      case (cfg.index)
        pqit_pkg::RegGate: gate_distance_mm <= cfg.data[pqit_pkg::GateW-1:0];
        pqit_pkg::RegHyst: hysteresis_mm <= cfg.data[pqit_pkg::HystW-1:0];
        pqit_pkg::RegRun: begin
          away_run_length <= cfg.data[pqit_pkg::RunW-1:0];
          // run count follows the new length only while absent
          if (!present_flag) begin
            far_run <= cfg.data[pqit_pkg::RunW-1:0];
          end
        end
        pqit_pkg::RegSettle: begin
          // settle count restarts from the new value
          settle_left <= cfg.data[pqit_pkg::SettleW-1:0];
        end
        pqit_pkg::RegRest: rest_after_ms <= cfg.data[pqit_pkg::IdleW-1:0];
        default: begin
          rest_after_ms <= rest_after_ms;
        end
      endcase
    end else if (accept) begin
      settle_left  <= settle_left_next;
      far_run      <= far_run_next;
      present_flag <= present_flag_next;
      idle_ms      <= idle_ms_next;
    end
  end

endmodule

[rtl/core/presence_qualifier_idle_timer_top.sv]
// presence qualifier with idle timer: top level with output register and skid stage
// result path: registered in the output register, or parked in the skid register
// throughput: one event per cycle while in_stall is low; the per-event compare and
// count logic sits between the state registers and the result register
// a skid register takes one more result while the output is stalled
// reset: synchronous active-high rst restores register defaults and start-up state
`include "presence_qualifier_idle_timer_top_defines.svh"

module presence_qualifier_idle_timer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] range_mm,
  input  logic        range_status_ok,
  input  logic        screen_hold,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        present_now,
  output logic [1:0]  presence_edge,
  output logic        rest_request
);

  pqit_pkg::cfg_wr_t cfg;
  pqit_pkg::result_t res;
  pqit_pkg::result_t out_res;
  pqit_pkg::result_t skid_res;
  logic              skid_valid;
  logic              in_xfer;
  logic              out_xfer;
  logic              out_held;
  logic              out_on;
  logic              out_off;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  pqit_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (in_xfer),
    .action          (action),
    .range_mm        (range_mm),
    .range_status_ok (range_status_ok),
    .screen_hold     (screen_hold),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        // output still waiting, park the new result
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  assign present_now   = out_res.present_now;
  assign presence_edge = out_res.presence_edge;
  assign rest_request  = out_res.rest_request;

  assign out_held = out_valid && out_stall;
  assign out_on   = out_valid && (presence_edge == pqit_pkg::EDGE_ON);
  assign out_off  = out_valid && (presence_edge == pqit_pkg::EDGE_OFF);

  `PQIT_ASSERT(a_skid_implies_out, !skid_valid || out_valid, "skid full with empty output")
  `PQIT_ASSERT_NEXT(a_park_on_stall, out_held && in_xfer, skid_valid, "stalled transfer not parked")
  `PQIT_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid, "skid did not drain")
  `PQIT_ASSERT(a_edge_on_matches, !out_on || present_now, "on edge without presence")
  `PQIT_ASSERT(a_edge_off_matches, !out_off || !present_now, "off edge with presence")

endmodule
